// ===== rtl/assert_macros.svh =====
// Assertion helpers; clocked on clk, off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fav_pkg.sv =====
`default_nettype none
package fav_pkg;

	localparam int COORD_BITS  = 24;
	localparam int MAX_CORNERS = 4;
	localparam int CIDX_W      = $clog2(MAX_CORNERS);
	localparam int CNT_W       = 3;
	localparam int DIFF_W      = COORD_BITS + 1;
	localparam int NORM_W      = 2 * COORD_BITS + 4;
	localparam int SPLIT_W     = NORM_W / 2;
	localparam int OPB_W       = SPLIT_W + 1;
	localparam int PROD_W      = DIFF_W + OPB_W;
	localparam int ACC_W       = DIFF_W + NORM_W + 3;

	localparam logic [1:0] KIND_CORNER = 2'd0;
	localparam logic [1:0] KIND_FACE   = 2'd1;
	localparam logic [1:0] KIND_CELL   = 2'd2;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic [1:0]                    kind;
		logic signed [COORD_BITS-1:0]  coord_x;
		logic signed [COORD_BITS-1:0]  coord_y;
		logic signed [COORD_BITS-1:0]  coord_z;
		logic                          last;
	} item_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic                     flipped;
		logic                     bad_corner_count;
	} result_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} coord3_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_LD_B,
		ST_MUL,
		ST_ACC,
		ST_SAVE,
		ST_D_LD,
		ST_D_MUL,
		ST_D_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic ld_a;
		logic ld_b;
		logic mul;
		logic acc_clr;
		logic acc_add;
		logic acc_shift;
		logic acc_neg;
	} mac_ctrl_t;

	typedef struct packed {
		logic [CIDX_W-1:0] ia;
		logic [CIDX_W-1:0] ja;
		logic [CIDX_W-1:0] ib;
		logic [CIDX_W-1:0] jb;
		logic [1:0]        ax_a;
		logic [1:0]        ax_b;
		logic              b_sub;
		logic              neg;
	} term_t;

	function automatic logic [1:0] next3(input logic [1:0] v);
		unique case (v)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick_axis(input coord3_t p,
			input logic [1:0] ax);
		unique case (ax)
			AX_X:    return p.x;
			AX_Y:    return p.y;
			default: return p.z;
		endcase
	endfunction

	function automatic term_t term_sel(input logic quad, input logic [1:0] comp,
			input logic [1:0] term);
		logic [1:0] b;
		logic [1:0] e;
		term_t      t;
		b = next3(comp);
		e = next3(b);
		if (quad) begin
			t.ia    = CIDX_W'(3);
			t.ja    = CIDX_W'(1);
			t.ib    = CIDX_W'(2);
			t.jb    = CIDX_W'(0);
			t.ax_a  = term[0] ? e : b;
			t.ax_b  = term[0] ? b : e;
			t.b_sub = 1'b1;
			t.neg   = term[0];
		end else begin
			t.ia    = CIDX_W'(term);
			t.ja    = CIDX_W'(next3(term));
			t.ib    = CIDX_W'(term);
			t.jb    = CIDX_W'(next3(term));
			t.ax_a  = b;
			t.ax_b  = e;
			t.b_sub = 1'b0;
			t.neg   = 1'b0;
		end
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/fav_corner_mem.sv =====
`default_nettype none
module fav_corner_mem
	import fav_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [CIDX_W-1:0] waddr,
	input  wire coord3_t           wdata,
	input  wire logic [CIDX_W-1:0] raddr0,
	input  wire logic [CIDX_W-1:0] raddr1,
	output coord3_t                rdata0,
	output coord3_t                rdata1
);

	coord3_t mem_q [MAX_CORNERS];
	coord3_t rd0_q;
	coord3_t rd1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd0_q <= mem_q[raddr0];
		rd1_q <= mem_q[raddr1];
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule
`default_nettype wire

// ===== rtl/fav_mac.sv =====
`default_nettype none
module fav_mac
	import fav_pkg::*;
(
	input  wire logic                     clk,
	input  wire mac_ctrl_t                ctrl,
	input  wire logic signed [DIFF_W-1:0] opa,
	input  wire logic signed [OPB_W-1:0]  opb,
	output logic signed [ACC_W-1:0]       acc
);

	logic signed [DIFF_W-1:0] op_a_q;
	logic signed [OPB_W-1:0]  op_b_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  shifted;
	logic signed [ACC_W-1:0]  addend;

	always_comb begin
		prod_ext = ACC_W'(prod_q);
		shifted  = ctrl.acc_shift ? (prod_ext <<< SPLIT_W) : prod_ext;
		addend   = ctrl.acc_neg ? -shifted : shifted;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_a) begin
			op_a_q <= opa;
		end
		if (ctrl.ld_b) begin
			op_b_q <= opb;
		end
		if (ctrl.mul) begin
			prod_q <= PROD_W'(op_a_q) * PROD_W'(op_b_q);
		end
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + addend;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// ===== rtl/fav_seq.sv =====
`default_nettype none
`include "assert_macros.svh"
module fav_seq
	import fav_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    quad_in,
	input  wire logic                    bad_in,
	input  wire logic                    slot_free,
	input  wire coord3_t                 face_ctr,
	input  wire coord3_t                 cell_ctr,
	input  wire coord3_t                 rdata0,
	input  wire coord3_t                 rdata1,
	input  wire logic signed [ACC_W-1:0] acc,
	output logic [CIDX_W-1:0]            raddr0,
	output logic [CIDX_W-1:0]            raddr1,
	output mac_ctrl_t                    ctrl,
	output logic signed [DIFF_W-1:0]     opa,
	output logic signed [OPB_W-1:0]      opb,
	output logic                         busy,
	output logic                         res_valid,
	output result_t                      res
);

	state_t                   state_q;
	state_t                   state_d;
	logic [1:0]               comp_q;
	logic [1:0]               term_q;
	logic                     quad_q;
	logic                     bad_q;
	logic signed [NORM_W-1:0] n_q [3];

	term_t                    sel;
	logic                     last_term;
	logic signed [DIFF_W-1:0] area_a;
	logic signed [DIFF_W-1:0] area_b;
	logic signed [DIFF_W-1:0] d_cur;
	logic signed [NORM_W-1:0] n_cur;
	logic signed [OPB_W-1:0]  dot_b;
	logic                     flip;

	always_comb begin
		sel       = term_sel(quad_q, comp_q, term_q);
		last_term = quad_q ? (term_q == 2'd1) : (term_q == 2'd2);
		area_a    = DIFF_W'(pick_axis(rdata0, sel.ax_a)) - DIFF_W'(pick_axis(rdata1, sel.ax_a));
		area_b    = sel.b_sub
			? DIFF_W'(pick_axis(rdata0, sel.ax_b)) - DIFF_W'(pick_axis(rdata1, sel.ax_b))
			: DIFF_W'(pick_axis(rdata0, sel.ax_b)) + DIFF_W'(pick_axis(rdata1, sel.ax_b));
		d_cur     = DIFF_W'(pick_axis(face_ctr, comp_q)) - DIFF_W'(pick_axis(cell_ctr, comp_q));
		unique case (comp_q)
			2'd1:    n_cur = n_q[1];
			2'd2:    n_cur = n_q[2];
			default: n_cur = n_q[0];
		endcase
		dot_b = term_q[0]
			? OPB_W'($signed(n_cur[NORM_W-1:SPLIT_W]))
			: $signed({1'b0, n_cur[SPLIT_W-1:0]});
		flip  = !bad_q && acc[ACC_W-1];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = bad_in ? ST_DONE : ST_RD_A;
				end
			end
			ST_RD_A:  state_d = ST_RD_B;
			ST_RD_B:  state_d = ST_LD_B;
			ST_LD_B:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = last_term ? ST_SAVE : ST_RD_A;
			ST_SAVE:  state_d = (comp_q == 2'd2) ? ST_D_LD : ST_RD_A;
			ST_D_LD:  state_d = ST_D_MUL;
			ST_D_MUL: state_d = ST_D_ACC;
			ST_D_ACC: state_d = (term_q[0] && comp_q == 2'd2) ? ST_DONE : ST_D_LD;
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl      = '0;
		res_valid = 1'b0;
		busy      = (state_q != ST_IDLE);
		raddr0    = (state_q == ST_RD_A) ? sel.ia : sel.ib;
		raddr1    = (state_q == ST_RD_A) ? sel.ja : sel.jb;
		opa       = (state_q == ST_D_LD) ? d_cur : area_a;
		opb       = (state_q == ST_D_LD) ? dot_b : OPB_W'(area_b);
		unique case (state_q)
			ST_IDLE:  ctrl.acc_clr = start;
			ST_RD_B:  ctrl.ld_a = 1'b1;
			ST_LD_B:  ctrl.ld_b = 1'b1;
			ST_MUL:   ctrl.mul = 1'b1;
			ST_ACC: begin
				ctrl.acc_add = 1'b1;
				ctrl.acc_neg = sel.neg;
			end
			ST_SAVE:  ctrl.acc_clr = 1'b1;
			ST_D_LD: begin
				ctrl.ld_a = 1'b1;
				ctrl.ld_b = 1'b1;
			end
			ST_D_MUL: ctrl.mul = 1'b1;
			ST_D_ACC: begin
				ctrl.acc_add   = 1'b1;
				ctrl.acc_shift = term_q[0];
			end
			ST_DONE:  res_valid = slot_free;
			default:  ctrl = '0;
		endcase
		res.normal_x         = bad_q ? '0 : (flip ? -n_q[0] : n_q[0]);
		res.normal_y         = bad_q ? '0 : (flip ? -n_q[1] : n_q[1]);
		res.normal_z         = bad_q ? '0 : (flip ? -n_q[2] : n_q[2]);
		res.flipped          = flip;
		res.bad_corner_count = bad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			comp_q  <= '0;
			term_q  <= '0;
			quad_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						comp_q <= '0;
						term_q <= '0;
						quad_q <= quad_in;
						bad_q  <= bad_in;
					end
				end
				ST_ACC:   term_q <= last_term ? 2'd0 : term_q + 2'd1;
				ST_SAVE: begin
					comp_q <= next3(comp_q);
					term_q <= '0;
				end
				ST_D_ACC: begin
					if (term_q[0]) begin
						comp_q <= next3(comp_q);
						term_q <= '0;
					end else begin
						term_q <= 2'd1;
					end
				end
				default: begin
					comp_q <= comp_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SAVE) begin
			unique case (comp_q)
				2'd1:    n_q[1] <= acc[NORM_W-1:0];
				2'd2:    n_q[2] <= acc[NORM_W-1:0];
				default: n_q[0] <= acc[NORM_W-1:0];
			endcase
		end
	end

	`ASSERT_IMPL(a_start_idle, start, state_q == ST_IDLE, "face start while busy")
	`ASSERT_IMPL(a_quad_terms, (state_q != ST_IDLE) && quad_q, term_q != 2'd2, "quad term overrun")
	`ASSERT_NEXT(a_save_clears, state_q == ST_SAVE, acc == '0, "accumulator not cleared")

endmodule
`default_nettype wire

// ===== rtl/face_area_vector_oriented_top.sv =====
// Oriented face area vector. A face arrives as item transactions: its corners in order,
// then its face center, then its left cell center, the final one marked last. Items not
// marked last are taken one per cycle. After the last item ready drops while a single
// shared 25x27 multiply-accumulate unit works through the face: for a triangle an edge term per
// edge and component, each with corner reads from a two-port store, a multiply and an accumulate,
// plus a low and a high dot product partial product per component; for a quad a pair of diagonal
// cross product terms per component instead of edge terms; for a bad corner count no arithmetic
// at all. The result sits in an output register, so the next face's items are taken while it waits
// for the consumer; a face that finishes before that result is taken holds ready low until it is.
`default_nettype none
`include "assert_macros.svh"
module face_area_vector_oriented_top
	import fav_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_ready,
	output result_t    result
);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     cnt_inc;
	coord3_t              face_ctr_q;
	coord3_t              cell_ctr_q;
	coord3_t              coord_in;
	logic                 result_valid_q;
	result_t              result_q;

	logic                 accept;
	logic                 is_corner;
	logic                 mem_we;
	logic                 start;
	logic                 quad_in;
	logic                 bad_in;
	logic                 slot_free;
	logic                 vec_zero;
	logic                 busy;
	logic                 res_valid;
	result_t              res;
	logic [CIDX_W-1:0]    raddr0;
	logic [CIDX_W-1:0]    raddr1;
	coord3_t              rdata0;
	coord3_t              rdata1;
	mac_ctrl_t            ctrl;
	logic signed [DIFF_W-1:0] opa;
	logic signed [OPB_W-1:0]  opb;
	logic signed [ACC_W-1:0]  acc;

	always_comb begin
		item_ready = !busy;
		accept     = item_valid && item_ready;
		is_corner  = (item.kind == KIND_CORNER);
		coord_in.x = item.coord_x;
		coord_in.y = item.coord_y;
		coord_in.z = item.coord_z;
		cnt_inc    = (is_corner && count_q != '1) ? count_q + CNT_W'(1) : count_q;
		mem_we     = accept && is_corner && (count_q < CNT_W'(MAX_CORNERS));
		start      = accept && item.last;
		quad_in    = (cnt_inc == CNT_W'(4));
		bad_in     = !((cnt_inc == CNT_W'(3)) || (cnt_inc == CNT_W'(4)));
		slot_free  = !result_valid_q || result_ready;
		vec_zero   = (result.normal_x == '0) && (result.normal_y == '0)
			&& (result.normal_z == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			face_ctr_q     <= '0;
			cell_ctr_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= item.last ? '0 : cnt_inc;
				if (item.kind == KIND_FACE) begin
					face_ctr_q <= coord_in;
				end
				if (item.kind == KIND_CELL) begin
					cell_ctr_q <= coord_in;
				end
			end
			if (res_valid) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	fav_corner_mem u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (count_q[CIDX_W-1:0]),
		.wdata  (coord_in),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	fav_mac u_mac (
		.clk  (clk),
		.ctrl (ctrl),
		.opa  (opa),
		.opb  (opb),
		.acc  (acc)
	);

	fav_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.quad_in   (quad_in),
		.bad_in    (bad_in),
		.slot_free (slot_free),
		.face_ctr  (face_ctr_q),
		.cell_ctr  (cell_ctr_q),
		.rdata0    (rdata0),
		.rdata1    (rdata1),
		.acc       (acc),
		.raddr0    (raddr0),
		.raddr1    (raddr1),
		.ctrl      (ctrl),
		.opa       (opa),
		.opb       (opb),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res)
	);

	`ASSERT_IMPL(a_bad_zero, result_valid && result.bad_corner_count, vec_zero && !result.flipped, "bad face with nonzero vector")
	`ASSERT_NEXT(a_count_clear, item_valid && item_ready && item.last, count_q == '0, "corner count not cleared")
	`ASSERT_IMPL(a_no_overwrite, res_valid, !result_valid || result_ready, "result overwritten")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
	import fav_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam int MAX_COUNT = 7;
	localparam int TARGET_ITEMS = 1300;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	bit steady;
	int items_sent;

	class face_vector_scoreboard;
		longint      corner_xyz[3*MAX_CORNERS];
		int unsigned corners_seen;
		longint      face_ctr[3];
		longint      cell_ctr[3];
		result_t     expected_vectors[$];
		int          mismatches;

		function new();
			foreach (corner_xyz[k]) corner_xyz[k] = 0;
			foreach (face_ctr[k]) begin
				face_ctr[k] = 0;
				cell_ctr[k] = 0;
			end
			corners_seen = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_vectors.size();
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		function void note_item(item_t it);
			longint               pt[3];
			longint               s[3];
			logic signed [127:0]  dot;
			logic signed [127:0]  dv;
			logic signed [127:0]  nv;
			bit                   bad;
			int                   b;
			int                   e;
			int                   j;
			result_t              r;
			pt[0] = it.coord_x;
			pt[1] = it.coord_y;
			pt[2] = it.coord_z;
			case (it.kind)
				KIND_CORNER: begin
					if (corners_seen < MAX_CORNERS)
						for (int k = 0; k < 3; k++)
							corner_xyz[3*corners_seen+k] = pt[k];
					if (corners_seen < MAX_COUNT)
						corners_seen++;
				end
				KIND_FACE: begin
					for (int k = 0; k < 3; k++) face_ctr[k] = pt[k];
				end
				KIND_CELL: begin
					for (int k = 0; k < 3; k++) cell_ctr[k] = pt[k];
				end
				default: ;
			endcase
			if (!it.last)
				return;
			for (int k = 0; k < 3; k++) s[k] = 0;
			bad = 1'b0;
			if (corners_seen == 3) begin
				for (int k = 0; k < 3; k++) begin
					b = (k + 1) % 3;
					e = (k + 2) % 3;
					for (int i = 0; i < 3; i++) begin
						j = (i + 1) % 3;
						s[k] += (corner_xyz[3*i+b] - corner_xyz[3*j+b])
							* (corner_xyz[3*i+e] + corner_xyz[3*j+e]);
					end
				end
			end else if (corners_seen == 4) begin
				longint da[3];
				longint db[3];
				for (int k = 0; k < 3; k++) begin
					da[k] = corner_xyz[9+k] - corner_xyz[3+k];
					db[k] = corner_xyz[6+k] - corner_xyz[k];
				end
				s[0] = da[1] * db[2] - da[2] * db[1];
				s[1] = da[2] * db[0] - da[0] * db[2];
				s[2] = da[0] * db[1] - da[1] * db[0];
			end else begin
				bad = 1'b1;
			end
			dot = 0;
			for (int k = 0; k < 3; k++) begin
				dv = face_ctr[k] - cell_ctr[k];
				nv = s[k];
				dot += dv * nv;
			end
			r.flipped = !bad && (dot < 0);
			if (r.flipped)
				for (int k = 0; k < 3; k++) s[k] = -s[k];
			r.normal_x = NORM_W'(s[0]);
			r.normal_y = NORM_W'(s[1]);
			r.normal_z = NORM_W'(s[2]);
			r.bad_corner_count = bad;
			expected_vectors = {expected_vectors, r};
			corners_seen = 0;
		endfunction

		task check_result(result_t got);
			result_t want;
			if (expected_vectors.size() == 0) begin
				report($sformatf("unexpected result x=%0d y=%0d z=%0d",
					got.normal_x, got.normal_y, got.normal_z));
				return;
			end
			want = expected_vectors.pop_front();
			if (got.normal_x !== want.normal_x)
				report($sformatf("normal_x %0d, want %0d", got.normal_x, want.normal_x));
			if (got.normal_y !== want.normal_y)
				report($sformatf("normal_y %0d, want %0d", got.normal_y, want.normal_y));
			if (got.normal_z !== want.normal_z)
				report($sformatf("normal_z %0d, want %0d", got.normal_z, want.normal_z));
			if (got.flipped !== want.flipped)
				report($sformatf("flipped %b, want %b", got.flipped, want.flipped));
			if (got.bad_corner_count !== want.bad_corner_count)
				report($sformatf("bad_corner_count %b, want %b",
					got.bad_corner_count, want.bad_corner_count));
		endtask
	endclass

	face_vector_scoreboard faces;

	face_area_vector_oriented_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic item_t mk(input logic [1:0] kind, input logic [COORD_BITS-1:0] x,
			input logic [COORD_BITS-1:0] y, input logic [COORD_BITS-1:0] z,
			input logic last);
		item_t it;
		it.kind    = kind;
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		it.last    = last;
		return it;
	endfunction

	function automatic logic [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0:       return C_MAX;
			1:       return C_MIN;
			2, 3:    return COORD_BITS'(int'($urandom_range(0, 8192)) - 4096);
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic item_t rand_point(input logic [1:0] kind);
		return mk(kind, rand_coord(), rand_coord(), rand_coord(), 1'b0);
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		faces.note_item(it);
		if (it.kind != KIND_SPARE || it.last)
			items_sent++;
	endtask

	task automatic wait_quiet();
		item_valid <= 1'b0;
		@(posedge clk);
		while (faces.pending() != 0) @(posedge clk);
	endtask

	task automatic random_face();
		item_t q[$];
		item_t ctr;
		int    n;
		if ($urandom_range(0, 4) != 0) begin
			n = 3 + $urandom_range(0, 1);
			for (int i = 0; i < n; i++) begin
				q = {q, rand_point(KIND_CORNER)};
				if ($urandom_range(0, 15) == 0)
					q = {q, rand_point(KIND_SPARE)};
			end
			ctr = rand_point(KIND_FACE);
			if ($urandom_range(0, 9) != 0)
				q = {q, ctr};
			if ($urandom_range(0, 9) != 0) begin
				if ($urandom_range(0, 15) == 0) begin
					ctr.kind = KIND_CELL;
					q = {q, ctr};
				end else begin
					q = {q, rand_point(KIND_CELL)};
				end
			end
		end else begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++)
				q = {q, rand_point($urandom_range(0, 2) == 0 ?
					2'($urandom_range(0, 3)) : KIND_CORNER)};
		end
		q[q.size()-1].last = 1'b1;
		foreach (q[i]) send_item(q[i]);
	endtask

	initial begin
		int stall;
		result_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (result_valid !== 1'b1) @(posedge clk);
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && result_ready)
			faces.check_result(result);

	initial begin
		#1000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int faces_done;
		faces = new();
		steady = 1'b0;
		items_sent = 0;
		faces_done = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// triangle at the coordinate extremes, centers equal so the dot product is zero
		send_item(mk(KIND_CORNER, C_MAX, C_MIN, C_MAX, 1'b0));
		send_item(mk(KIND_CORNER, C_MIN, C_MAX, C_MAX, 1'b0));
		send_item(mk(KIND_CORNER, C_MAX, C_MAX, C_MIN, 1'b0));
		send_item(mk(KIND_FACE, COORD_BITS'(5), COORD_BITS'(5), COORD_BITS'(5), 1'b0));
		send_item(mk(KIND_CELL, COORD_BITS'(5), COORD_BITS'(5), COORD_BITS'(5), 1'b1));
		// quad spanning the full range
		send_item(mk(KIND_CORNER, C_MIN, C_MIN, COORD_BITS'(0), 1'b0));
		send_item(mk(KIND_CORNER, C_MAX, C_MIN, COORD_BITS'(0), 1'b0));
		send_item(mk(KIND_CORNER, C_MAX, C_MAX, COORD_BITS'(0), 1'b0));
		send_item(mk(KIND_CORNER, C_MIN, C_MAX, COORD_BITS'(0), 1'b0));
		send_item(mk(KIND_FACE, COORD_BITS'(0), COORD_BITS'(0), COORD_BITS'(-4096), 1'b0));
		send_item(mk(KIND_CELL, COORD_BITS'(0), COORD_BITS'(0), COORD_BITS'(4096), 1'b1));
		// two corners only
		send_item(mk(KIND_CORNER, COORD_BITS'(1), COORD_BITS'(2), COORD_BITS'(3), 1'b0));
		send_item(mk(KIND_CORNER, C_MIN, C_MAX, C_MIN, 1'b1));
		// five corners
		for (int i = 0; i < 5; i++)
			send_item(mk(KIND_CORNER, COORD_BITS'(4096 * i), COORD_BITS'(-4096 * i),
				C_MAX, i == 4));
		// unknown kind closes a triangle, centers reused from before
		send_item(mk(KIND_CORNER, COORD_BITS'(0), COORD_BITS'(0), COORD_BITS'(0), 1'b0));
		send_item(mk(KIND_CORNER, C_MAX, COORD_BITS'(0), COORD_BITS'(0), 1'b0));
		send_item(mk(KIND_CORNER, COORD_BITS'(0), C_MAX, COORD_BITS'(0), 1'b0));
		send_item(mk(KIND_SPARE, C_MAX, C_MIN, C_MAX, 1'b1));
		// no corners at all
		send_item(mk(KIND_FACE, C_MIN, C_MAX, COORD_BITS'(7), 1'b1));
		wait_quiet();

		while (items_sent < TARGET_ITEMS) begin
			steady = ($urandom_range(0, 5) == 0);
			random_face();
			faces_done++;
			if (faces_done % 40 == 0)
				wait_quiet();
		end
		steady = 1'b0;
		wait_quiet();
		repeat (100) @(posedge clk);

		if (faces.mismatches == 0 && faces.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/fav_pkg.sv
rtl/fav_corner_mem.sv
rtl/fav_mac.sv
rtl/fav_seq.sv
rtl/face_area_vector_oriented_top.sv
tb/sv/testbench.sv
